// ===== rtl/gbpc_pkg.sv =====
package gbpc_pkg;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam int CNT_W   = 7;
    localparam int COORD_W = 6;
    localparam int EPOCH_W = 8;

    localparam logic [1:0] DIR_PX = 2'd0;
    localparam logic [1:0] DIR_MX = 2'd1;
    localparam logic [1:0] DIR_PY = 2'd2;
    localparam logic [1:0] DIR_MY = 2'd3;

    typedef struct packed {
        logic       load_wr;
        logic       search_init;
        logic       reject;
        logic       epoch_inc;
        logic       clear_step;
        logic       clear_fin;
        logic       start_push;
        logic       pop;
        logic       goal_chk;
        logic       nbr_issue;
        logic [1:0] nbr_dir;
        logic       nbr_chk;
        logic       emit_final;
    } t_cmd;

    typedef struct packed {
        logic search_bad;
        logic epoch_max;
        logic clear_last;
        logic queue_empty;
        logic limit_hit;
    } t_stat;

endpackage

// ===== rtl/grid_bfs_passable_collector.sv =====
// A load writes its cell without leaving idle. A search walks the map breadth
// first and returns its goals one per strobe, the final one flagged by o_last;
// an off-map start or a zero count gives one strobe with o_goal_valid low the
// cycle after the request. Each dequeued cell goes through a queue read, a
// passability read and four neighbor checks through the single visited port.
// The visited store is tagged by search epoch; after reset, and again every
// 255 searches, a clearing pass over all 2**(clog2(MAP_W)+clog2(MAP_H))
// entries runs while busy is high. Results cannot be stalled: each one is on
// the output ports for exactly one cycle and must be taken then.
module grid_bfs_passable_collector
    import gbpc_pkg::*;
#(
    parameter int MAP_W     = 64,
    parameter int MAP_H     = 64,
    parameter int MAX_GOALS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_opcode,
    input  logic [7:0]         i_cell_x,
    input  logic [7:0]         i_cell_y,
    input  logic               i_passable,
    input  logic [CNT_W-1:0]   i_want_count,
    output logic               o_strobe,
    output logic [COORD_W-1:0] o_goal_x,
    output logic [COORD_W-1:0] o_goal_y,
    output logic               o_goal_valid,
    output logic               o_last
);

    t_cmd  cmd;
    t_stat stat;

    gbpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    gbpc_dp #(
        .MAP_W     (MAP_W),
        .MAP_H     (MAP_H),
        .MAX_GOALS (MAX_GOALS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_passable   (i_passable),
        .i_want_count (i_want_count),
        .o_stat       (stat),
        .o_strobe     (o_strobe),
        .o_goal_x     (o_goal_x),
        .o_goal_y     (o_goal_y),
        .o_goal_valid (o_goal_valid),
        .o_last       (o_last)
    );

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_wr, cmd.search_init, cmd.reject, cmd.clear_step,
                  cmd.start_push, cmd.pop, cmd.emit_final}))
        else $error("more than one sequencer step active");

    a_final_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_final |=> o_strobe && o_last)
        else $error("search end did not produce a final result");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_goal_valid |-> o_last)
        else $error("empty result not marked last");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> busy)
        else $error("search went idle before its last result");

endmodule

// ===== rtl/gbpc_ctrl.sv =====
module gbpc_ctrl
    import gbpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  i_opcode,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_NBR   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_dir, n_dir;
    logic       r_after, n_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_dir   <= '0;
            r_after <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
            r_after <= n_after;
        end
    end

    always_comb begin
        n_state = r_state;
        n_dir   = r_dir;
        n_after = r_after;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else if (i_stat.search_bad) begin
                        o_cmd.reject = 1'b1;
                    end else begin
                        o_cmd.search_init = 1'b1;
                        // All epoch tags used up: sweep the visited store first.
                        if (i_stat.epoch_max) begin
                            n_state = S_CLEAR;
                            n_after = 1'b1;
                        end else begin
                            o_cmd.epoch_inc = 1'b1;
                            n_state = S_START;
                        end
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    o_cmd.clear_fin = 1'b1;
                    n_state = r_after ? S_START : S_IDLE;
                    n_after = 1'b0;
                end
            end
            S_START: begin
                o_cmd.start_push = 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                if (i_stat.queue_empty || i_stat.limit_hit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_dir = '0;
                n_state = S_NBR;
            end
            S_NBR: begin
                // Each neighbor read is issued in the cycle before its check.
                o_cmd.goal_chk  = (r_dir == 3'd0);
                o_cmd.nbr_issue = !r_dir[2];
                o_cmd.nbr_dir   = r_dir[1:0];
                o_cmd.nbr_chk   = (r_dir != 3'd0);
                n_dir = r_dir + 3'd1;
                if (r_dir[2]) begin
                    n_state = S_POP;
                end
            end
            S_DONE: begin
                o_cmd.emit_final = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== rtl/gbpc_dp.sv =====
module gbpc_dp
    import gbpc_pkg::*;
#(
    parameter int MAP_W     = 64,
    parameter int MAP_H     = 64,
    parameter int MAX_GOALS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [7:0]         i_cell_x,
    input  logic [7:0]         i_cell_y,
    input  logic               i_passable,
    input  logic [CNT_W-1:0]   i_want_count,
    output t_stat              o_stat,
    output logic               o_strobe,
    output logic [COORD_W-1:0] o_goal_x,
    output logic [COORD_W-1:0] o_goal_y,
    output logic               o_goal_valid,
    output logic               o_last
);

    localparam int XW  = $clog2(MAP_W);
    localparam int YW  = $clog2(MAP_H);
    localparam int AW  = XW + YW;
    localparam int QD  = MAP_W * MAP_H;
    localparam int QAW = $clog2(QD);
    localparam int QW  = $clog2(QD + 1);

    localparam logic [8:0]       W_LIM   = 9'(MAP_W);
    localparam logic [8:0]       H_LIM   = 9'(MAP_H);
    localparam logic [CNT_W-1:0] GOAL_LIM = CNT_W'(MAX_GOALS);
    localparam logic [XW-1:0]    X_LAST  = XW'(MAP_W - 1);
    localparam logic [YW-1:0]    Y_LAST  = YW'(MAP_H - 1);

    logic               pmem [2**AW];
    logic [EPOCH_W-1:0] vmem [2**AW];
    logic [AW-1:0]      qmem [QD];

    logic               r_prd;
    logic [EPOCH_W-1:0] r_vrd;
    logic [AW-1:0]      r_qrd;

    logic [XW-1:0]      r_sx, r_cx, r_px;
    logic [YW-1:0]      r_sy, r_cy, r_py;
    logic [CNT_W-1:0]   r_limit, r_placed;
    logic [QW-1:0]      r_head, r_tail;
    logic [EPOCH_W-1:0] r_epoch;
    logic [AW-1:0]      r_clr;
    logic               r_pend_v;
    logic               r_nb_ok;
    logic [AW-1:0]      r_nb_addr;

    logic               r_strobe, n_strobe;
    logic [XW-1:0]      r_ox, n_ox;
    logic [YW-1:0]      r_oy, n_oy;
    logic               r_ovalid, n_ovalid;
    logic               r_olast, n_olast;

    logic               in_map;
    logic [AW-1:0]      in_addr;
    logic [XW-1:0]      nx;
    logic [YW-1:0]      ny;
    logic               nb_ok;
    logic [AW-1:0]      nb_addr;
    logic               nb_new;
    logic               v_we;
    logic [AW-1:0]      v_wa;
    logic [EPOCH_W-1:0] v_wd;
    logic               q_we;
    logic [QAW-1:0]     q_wa;
    logic [AW-1:0]      q_wd;

    assign in_map  = ({1'b0, i_cell_x} < W_LIM) && ({1'b0, i_cell_y} < H_LIM);
    assign in_addr = {i_cell_y[YW-1:0], i_cell_x[XW-1:0]};

    assign o_stat.search_bad  = !in_map || (i_want_count == '0);
    assign o_stat.epoch_max   = &r_epoch;
    assign o_stat.clear_last  = &r_clr;
    assign o_stat.queue_empty = (r_head == r_tail);
    assign o_stat.limit_hit   = (r_placed >= r_limit);

    always_comb begin
        nx    = r_cx;
        ny    = r_cy;
        nb_ok = 1'b0;
        case (i_cmd.nbr_dir)
            DIR_PX: begin
                nx    = r_cx + XW'(1);
                nb_ok = (r_cx != X_LAST);
            end
            DIR_MX: begin
                nx    = r_cx - XW'(1);
                nb_ok = (r_cx != '0);
            end
            DIR_PY: begin
                ny    = r_cy + YW'(1);
                nb_ok = (r_cy != Y_LAST);
            end
            DIR_MY: begin
                ny    = r_cy - YW'(1);
                nb_ok = (r_cy != '0);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end
    assign nb_addr = {ny, nx};

    // A cell counts as visited only if its tag matches the current search.
    assign nb_new = i_cmd.nbr_chk && r_nb_ok && (r_vrd != r_epoch);

    always_comb begin
        v_we = 1'b0;
        v_wa = r_nb_addr;
        v_wd = r_epoch;
        q_we = 1'b0;
        q_wa = r_tail[QAW-1:0];
        q_wd = r_nb_addr;
        if (i_cmd.clear_step) begin
            v_we = 1'b1;
            v_wa = r_clr;
            v_wd = '0;
        end else if (i_cmd.start_push) begin
            v_we = 1'b1;
            v_wa = {r_sy, r_sx};
            q_we = 1'b1;
            q_wa = '0;
            q_wd = {r_sy, r_sx};
        end else if (nb_new) begin
            v_we = 1'b1;
            q_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && in_map) begin
            pmem[in_addr] <= i_passable;
        end
        r_prd <= pmem[r_qrd];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            vmem[v_wa] <= v_wd;
        end
        r_vrd <= vmem[nb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            qmem[q_wa] <= q_wd;
        end
        // An entry written at the head in the same cycle is passed straight through.
        r_qrd <= (q_we && (q_wa == r_head[QAW-1:0])) ? q_wd : qmem[r_head[QAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search_init) begin
            r_sx    <= i_cell_x[XW-1:0];
            r_sy    <= i_cell_y[YW-1:0];
            r_limit <= (i_want_count > GOAL_LIM) ? GOAL_LIM : i_want_count;
        end
        if (i_cmd.pop) begin
            {r_cy, r_cx} <= r_qrd;
        end
        if (i_cmd.nbr_issue) begin
            r_nb_ok   <= nb_ok;
            r_nb_addr <= nb_addr;
        end
        if (i_cmd.goal_chk && r_prd) begin
            r_px <= r_cx;
            r_py <= r_cy;
        end
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_ovalid <= n_ovalid;
        r_olast  <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_placed <= '0;
            r_pend_v <= 1'b0;
            r_epoch  <= '0;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_cmd.search_init) begin
                r_head   <= '0;
                r_tail   <= '0;
                r_placed <= '0;
                r_pend_v <= 1'b0;
            end
            if (i_cmd.epoch_inc) begin
                r_epoch <= r_epoch + EPOCH_W'(1);
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.clear_fin) begin
                r_epoch <= EPOCH_W'(1);
            end
            if (i_cmd.start_push) begin
                r_tail <= QW'(1);
            end else if (nb_new) begin
                r_tail <= r_tail + QW'(1);
            end
            if (i_cmd.pop) begin
                r_head <= r_head + QW'(1);
            end
            if (i_cmd.goal_chk && r_prd) begin
                r_placed <= r_placed + CNT_W'(1);
                r_pend_v <= 1'b1;
            end
        end
    end

    // A goal is held back one step so that the final one can carry last.
    always_comb begin
        n_strobe = 1'b0;
        n_ox     = r_px;
        n_oy     = r_py;
        n_ovalid = 1'b1;
        n_olast  = 1'b0;
        if (i_cmd.reject || (i_cmd.emit_final && !r_pend_v)) begin
            n_strobe = 1'b1;
            n_ox     = '0;
            n_oy     = '0;
            n_ovalid = 1'b0;
            n_olast  = 1'b1;
        end else if (i_cmd.emit_final) begin
            n_strobe = 1'b1;
            n_olast  = 1'b1;
        end else if (i_cmd.goal_chk && r_prd && r_pend_v) begin
            n_strobe = 1'b1;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_goal_x     = COORD_W'(r_ox);
    assign o_goal_y     = COORD_W'(r_oy);
    assign o_goal_valid = r_ovalid;
    assign o_last       = r_olast;

endmodule
